// ===== src/profile_torque_ramp_macros.svh =====
`ifndef PROFILE_TORQUE_RAMP_MACROS_SVH
`define PROFILE_TORQUE_RAMP_MACROS_SVH

// Both macros sample on clk and are disabled while arst_n is low.
// The module that uses them must have signals of those names.

// Consequent must hold in the same cycle as the antecedent.
`define PTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ptr_pkg.sv =====
`timescale 1ns / 1ps

package ptr_pkg;

	localparam int CFG_DATA_W = 23;
	localparam int STEP_W     = 25;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_RAMP_SLOPE   = 2'd0,
		REG_HALT_OPTION  = 2'd1,
		REG_QSTOP_OPTION = 2'd2,
		REG_INVERT       = 2'd3
	} ptr_reg_t;

	localparam logic signed [15:0] TORQUE_LIMIT  = 16'sd5000;
	localparam logic signed [28:0] RAMP_LIMIT_Q15 = 29'sd163840000;

	// floor(x / 125) = (x * RECIP_125) >> 38 for x below 2**31; x = slope << 8.
	localparam logic [31:0] RECIP_125   = 32'd2199023256;
	localparam int          RECIP_SHIFT = 30;

	localparam logic [3:0] HALT_IMMEDIATE   = 4'd3;
	localparam logic [3:0] QSTOP_COAST      = 4'd0;
	localparam logic [3:0] QSTOP_RAMP_SLOW  = 4'd1;
	localparam logic [3:0] QSTOP_RAMP_FAST  = 4'd2;
	localparam logic [3:0] DRV_NOT_READY    = 4'd0;
	localparam logic [3:0] DRV_SW_DISABLED  = 4'd1;
	localparam logic [1:0] HIST_FIRST       = 2'b01;
	localparam logic [1:0] HIST_HELD        = 2'b11;

	typedef struct packed {
		logic [22:0] ramp_slope;
		logic [3:0]  halt_option;
		logic [3:0]  quick_stop_option;
		logic        invert_torque;
	} ptr_cfg_t;

	typedef struct packed {
		logic               torque_mode;
		logic               drive_enabled;
		logic signed [15:0] torque_demand;
		logic               halt_request;
		logic               quick_stop_bit;
		logic [3:0]         drive_state;
		logic               quick_stop_latched;
	} ptr_item_t;

	typedef struct packed {
		logic signed [13:0] torque_out;
		logic               torque_reached;
		logic               disable_request;
	} ptr_result_t;

endpackage

// ===== src/ptr_stream_if.sv =====
`timescale 1ns / 1ps

interface ptr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/profile_torque_ramp.sv =====
`timescale 1ns / 1ps

`include "profile_torque_ramp_macros.svh"

// Profile torque ramp, one control tick per input word.
// Input channel (item): drive mode, enable, target torque and control word bits.
// Output channel (result): ramped torque, reached flag and disable request.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 slope,
// 1 halt option, 2 quick stop option, 3 invert); write only while no word is
// in flight.
// From acceptance to result valid, an input stage first holds the word and
// the step derived from the slope multiplier, and the output register then
// takes the ramp update once the output is free.
// Throughput is one word per cycle while the receiver takes results.
// When the receiver stalls, the output register holds its word and the input
// stage takes one more word, then ready drops until the output drains.
// Reset clears the ramp value, both histories and the pipeline, and loads the
// registers with slope 1, halt option 1, quick stop option 2, no inversion.
module profile_torque_ramp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  ptr_pkg::ptr_reg_t              cfg_index,
	input  logic [ptr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ptr_stream_if.sink                     item,
	ptr_stream_if.source                   result
);
	import ptr_pkg::*;

	ptr_cfg_t              cfg_q;
	ptr_item_t             item_s1;
	logic [STEP_W-1:0]     step_s1;
	logic                  valid_s1;
	ptr_result_t           result_s2;
	logic                  valid_s2;
	logic [STEP_W-1:0]     step;
	ptr_result_t           res;
	logic                  accept;
	logic                  advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_slope        <= 23'd1;
			cfg_q.halt_option       <= 4'd1;
			cfg_q.quick_stop_option <= 4'd2;
			cfg_q.invert_torque     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAMP_SLOPE:   cfg_q.ramp_slope        <= cfg_wdata;
				REG_HALT_OPTION:  cfg_q.halt_option       <= cfg_wdata[3:0];
				REG_QSTOP_OPTION: cfg_q.quick_stop_option <= cfg_wdata[3:0];
				REG_INVERT:       cfg_q.invert_torque     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	ptr_step_calc u_step (
		.ramp_slope (cfg_q.ramp_slope),
		.step       (step)
	);

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.data;
			step_s1 <= step;
		end
		if (advance) begin
			result_s2 <= res;
		end
	end

	ptr_ramp u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_q),
		.item    (item_s1),
		.step    (step_s1),
		.res     (res)
	);

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

	`PTR_ASSERT_NEXT(a_accept_fills, accept, valid_s1, "accepted word missing from input stage")
	`PTR_ASSERT_NOW(a_empty_ready, !valid_s2, item.ready, "input blocked with empty output")
	`PTR_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1, "input stage lost a stalled word")

endmodule

// ===== src/ptr_step_calc.sv =====
`timescale 1ns / 1ps

module ptr_step_calc (
	input  logic [22:0]                  ramp_slope,
	output logic [ptr_pkg::STEP_W-1:0]   step
);
	import ptr_pkg::*;

	logic [22:0] slope_eff;
	logic [54:0] prod;

	// A slope of zero behaves as a slope of one.
	assign slope_eff = (ramp_slope == '0) ? 23'd1 : ramp_slope;
	assign prod      = 55'(slope_eff) * 55'(RECIP_125);
	assign step      = prod[RECIP_SHIFT +: STEP_W];

endmodule

// ===== src/ptr_ramp.sv =====
`timescale 1ns / 1ps

`include "profile_torque_ramp_macros.svh"

module ptr_ramp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  ptr_pkg::ptr_cfg_t           cfg,
	input  ptr_pkg::ptr_item_t          item,
	input  logic [ptr_pkg::STEP_W-1:0]  step,
	output ptr_pkg::ptr_result_t        res
);
	import ptr_pkg::*;

	logic signed [28:0] ramp_q;
	logic [1:0]         halt_hist_q;
	logic [1:0]         qs_hist_q;

	logic               active;
	logic [1:0]         halt_hist_d;
	logic [1:0]         qs_hist_d;
	logic signed [13:0] clamped;
	logic signed [30:0] cur_w;
	logic signed [30:0] tq_w;
	logic signed [30:0] step_w;
	logic signed [30:0] sum_w;
	logic signed [30:0] dif_w;
	logic signed [30:0] next_w;
	logic signed [13:0] torque;
	logic               reached;
	logic               disable_req;

	always_comb begin
		active      = item.torque_mode & item.drive_enabled;
		halt_hist_d = {halt_hist_q[0], item.halt_request};
		qs_hist_d   = {qs_hist_q[0], ~item.quick_stop_bit};
		cur_w       = {{2{ramp_q[28]}}, ramp_q};
		step_w      = {{(31 - STEP_W){1'b0}}, step};
		disable_req = 1'b0;
		reached     = 1'b0;

		if (item.torque_demand > TORQUE_LIMIT) begin
			clamped = TORQUE_LIMIT[13:0];
		end else if (item.torque_demand < -TORQUE_LIMIT) begin
			clamped = -TORQUE_LIMIT[13:0];
		end else begin
			clamped = item.torque_demand[13:0];
		end
		tq_w = {{2{clamped[13]}}, clamped, 15'b0};

		if (halt_hist_d == HIST_HELD) begin
			tq_w = '0;
			if (cfg.halt_option == HALT_IMMEDIATE) begin
				step_w = (cur_w < 0) ? -cur_w : cur_w;
			end
		end

		if (qs_hist_d == HIST_FIRST) begin
			disable_req = (cfg.quick_stop_option == QSTOP_COAST) &&
				(item.drive_state == DRV_NOT_READY);
		end else if (qs_hist_d == HIST_HELD) begin
			tq_w = '0;
			if (cur_w == 0 && (cfg.quick_stop_option == QSTOP_RAMP_SLOW ||
					cfg.quick_stop_option == QSTOP_RAMP_FAST)) begin
				disable_req = (item.drive_state == DRV_NOT_READY) ||
					(item.drive_state == DRV_SW_DISABLED && item.quick_stop_latched);
			end
		end

		sum_w = cur_w + step_w;
		dif_w = cur_w - step_w;
		// Clamping onto the target is what raises the reached flag.
		if (cur_w <= tq_w) begin
			if (sum_w > tq_w) begin
				next_w  = tq_w;
				reached = 1'b1;
			end else begin
				next_w = sum_w;
			end
		end else begin
			if (dif_w < tq_w) begin
				next_w  = tq_w;
				reached = 1'b1;
			end else begin
				next_w = dif_w;
			end
		end

		torque = next_w[28:15];
		if (!active) begin
			torque      = '0;
			reached     = 1'b0;
			disable_req = 1'b0;
		end
		res.torque_out      = cfg.invert_torque ? -torque : torque;
		res.torque_reached  = reached;
		res.disable_request = disable_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q      <= '0;
			halt_hist_q <= '0;
			qs_hist_q   <= '0;
		end else if (advance) begin
			if (active) begin
				ramp_q      <= next_w[28:0];
				halt_hist_q <= halt_hist_d;
				qs_hist_q   <= qs_hist_d;
			end else begin
				ramp_q <= '0;
			end
		end
	end

	`PTR_ASSERT_NOW(a_ramp_bound, 1'b1, (ramp_q <= RAMP_LIMIT_Q15) && (ramp_q >= -RAMP_LIMIT_Q15), "ramp value left the clamp range")
	`PTR_ASSERT_NEXT(a_inactive_clear, advance && !active, ramp_q == 0, "ramp not cleared while inactive")
	`PTR_ASSERT_NEXT(a_hist_hold, !advance, $stable(halt_hist_q) && $stable(qs_hist_q), "history moved without a word")

endmodule
